FILE: rtl/tasf_pkg.sv
// ---------------------------------------------------------------------------
// tasf_pkg: shared types and constants for the thumb alu / shifter core
// Operation codes, shift kinds, flag and result bundles.
// ---------------------------------------------------------------------------
package tasf_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned FUNC_W  = 5;
   localparam int unsigned AMT_W   = 8;
   localparam int unsigned REG_W   = 4;

   localparam logic [REG_W-1:0] PC_REG      = 4'd15;
   localparam logic [AMT_W-1:0] FULL_SHIFT  = 8'd32;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FN_AND     = 5'd0,
      FN_EOR     = 5'd1,
      FN_SUB     = 5'd2,
      FN_RSB     = 5'd3,
      FN_ADD     = 5'd4,
      FN_ADC     = 5'd5,
      FN_SBC     = 5'd6,
      FN_RSC     = 5'd7,
      FN_TST     = 5'd8,
      FN_TEQ     = 5'd9,
      FN_CMP     = 5'd10,
      FN_CMN     = 5'd11,
      FN_ORR     = 5'd12,
      FN_MOV     = 5'd13,
      FN_BIC     = 5'd14,
      FN_MVN     = 5'd15,
      FN_MOV2    = 5'd16,
      FN_LSL_IMM = 5'd17,
      FN_LSR_IMM = 5'd18,
      FN_ASR_IMM = 5'd19,
      FN_LSL_REG = 5'd20,
      FN_LSR_REG = 5'd21,
      FN_ASR_REG = 5'd22,
      FN_ROR_REG = 5'd23
   } func_type;

   // barrel shifter operations
   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   // one request as held in the input register
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] operand_n;
      logic [DATA_W-1:0] operand_m;
      logic [AMT_W-1:0]  shift_amount;
      logic [REG_W-1:0]  dest_reg;
   } req_type;

   // one result as held in the output register
   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic              write_enable;
      logic [REG_W-1:0]  dest_out;
      flags_type         flags;
      logic              pc_written;
   } rsp_type;

endpackage

FILE: rtl/tasf_if.sv
// ---------------------------------------------------------------------------
// tasf request and response channels
// Valid/ready channels carrying the alu request and result payloads.
// ---------------------------------------------------------------------------
interface tasf_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  func;
   logic [31:0] operand_n;
   logic [31:0] operand_m;
   logic [7:0]  shift_amount;
   logic [3:0]  dest_reg;

   modport source (output valid, func, operand_n, operand_m, shift_amount, dest_reg,
                   input ready);
   modport sink   (input valid, func, operand_n, operand_m, shift_amount, dest_reg,
                   output ready);
endinterface

interface tasf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        write_enable;
   logic [3:0]  dest_out;
   logic        flag_n;
   logic        flag_z;
   logic        flag_c;
   logic        flag_v;
   logic        pc_written;

   modport source (output valid, result_value, write_enable, dest_out, flag_n, flag_z,
                   flag_c, flag_v, pc_written, input ready);
   modport sink   (input valid, result_value, write_enable, dest_out, flag_n, flag_z,
                   flag_c, flag_v, pc_written, output ready);
endinterface

FILE: rtl/tasf_shifter.sv
// ---------------------------------------------------------------------------
// tasf_shifter: 32-bit barrel shifter with carry out
// LSL, LSR, ASR and ROR by a decoded 8-bit amount; zero keeps value and carry.
// ---------------------------------------------------------------------------
module tasf_shifter (
   input  tasf_pkg::shift_kind_type   kind,
   input  logic [tasf_pkg::AMT_W-1:0] amount,
   input  logic [tasf_pkg::DATA_W-1:0] value_in,
   input  logic                        carry_in,
   output logic [tasf_pkg::DATA_W-1:0] value_out,
   output logic                        carry_out
);
   import tasf_pkg::*;

   logic [DATA_W:0]          lsl_wide;
   logic [DATA_W:0]          lsr_wide;
   logic signed [DATA_W:0]   asr_wide;
   logic [2*DATA_W-1:0]      ror_wide;
   logic [4:0]               low_amt;
   logic                     amt_big;
   logic                     amt_full;

   // amounts of 1..31 go through the wide shifts, larger ones are special cases except for ROR
   assign low_amt  = amount[4:0];
   assign amt_big  = |amount[AMT_W-1:5];
   assign amt_full = (amount == FULL_SHIFT);
   assign lsl_wide = {1'b0, value_in} << low_amt;
   assign lsr_wide = {value_in, 1'b0} >> low_amt;
   assign asr_wide = $signed({value_in, 1'b0}) >>> low_amt;
   assign ror_wide = {value_in, value_in} >> low_amt;

   // result and carry selection
   always_comb begin
      value_out = value_in;
      carry_out = carry_in;
      if (amount != '0) begin
         unique case (kind)
            SH_LSL: begin
               if (!amt_big) begin
                  value_out = lsl_wide[DATA_W-1:0];
                  carry_out = lsl_wide[DATA_W];
               end else begin
                  value_out = '0;
                  carry_out = amt_full & value_in[0];
               end
            end
            SH_LSR: begin
               if (!amt_big) begin
                  value_out = lsr_wide[DATA_W:1];
                  carry_out = lsr_wide[0];
               end else begin
                  value_out = '0;
                  carry_out = amt_full & value_in[DATA_W-1];
               end
            end
            SH_ASR: begin
               if (!amt_big) begin
                  value_out = asr_wide[DATA_W:1];
                  carry_out = asr_wide[0];
               end else begin
                  value_out = {DATA_W{value_in[DATA_W-1]}};
                  carry_out = value_in[DATA_W-1];
               end
            end
            default: begin
               // rotate: a multiple of 32 leaves the value, carry is bit 31
               value_out = ror_wide[DATA_W-1:0];
               carry_out = ror_wide[DATA_W-1];
            end
         endcase
      end
   end

endmodule

FILE: rtl/tasf_alu.sv
// ---------------------------------------------------------------------------
// tasf_alu: one-pass execute logic
// Adder, logic unit and shifter for one request, with the new flags.
// ---------------------------------------------------------------------------
module tasf_alu (
   input  tasf_pkg::req_type   req,
   input  tasf_pkg::flags_type flags_cur,
   output tasf_pkg::rsp_type   rsp
);
   import tasf_pkg::*;

   logic [DATA_W-1:0] add_a;
   logic [DATA_W-1:0] add_b;
   logic              add_cin;
   logic [DATA_W:0]   add_sum;
   logic              add_v;
   shift_kind_type    sh_kind;
   logic [AMT_W-1:0]  sh_amt;
   logic [DATA_W-1:0] sh_value;
   logic              sh_carry;
   logic [DATA_W-1:0] res;
   logic              we;
   logic              set_nz;
   flags_type         flags_new;
   func_type          fn;

   assign fn = func_type'(req.func);

   // adder operand selection
   always_comb begin
      add_a   = req.operand_n;
      add_b   = req.operand_m;
      add_cin = 1'b0;
      unique case (fn)
         FN_SUB, FN_CMP: begin
            add_b   = ~req.operand_m;
            add_cin = 1'b1;
         end
         FN_RSB: begin
            add_a   = req.operand_m;
            add_b   = ~req.operand_n;
            add_cin = 1'b1;
         end
         FN_ADC: add_cin = flags_cur.c;
         FN_SBC: begin
            add_b   = ~req.operand_m;
            add_cin = flags_cur.c;
         end
         FN_RSC: begin
            add_a   = req.operand_m;
            add_b   = ~req.operand_n;
            add_cin = flags_cur.c;
         end
         default: ;
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
   assign add_v   = (add_a[DATA_W-1] ^ add_sum[DATA_W-1]) &
                    (add_b[DATA_W-1] ^ add_sum[DATA_W-1]);

   // shift kind and amount; immediate amount of zero means 32 for LSR/ASR
   always_comb begin
      sh_kind = shift_kind_type'(req.func[1:0] + 2'd3);
      sh_amt  = {3'b000, req.shift_amount[4:0]};
      if (fn == FN_LSL_REG || fn == FN_LSR_REG || fn == FN_ASR_REG || fn == FN_ROR_REG)
      begin
         sh_kind = shift_kind_type'(req.func[1:0]);
         sh_amt  = req.shift_amount;
      end else if (req.shift_amount[4:0] == 5'd0 && fn != FN_LSL_IMM) begin
         sh_amt = FULL_SHIFT;
      end
   end

   tasf_shifter u_shifter (
      .kind      (sh_kind),
      .amount    (sh_amt),
      .value_in  (req.operand_m),
      .carry_in  (flags_cur.c),
      .value_out (sh_value),
      .carry_out (sh_carry)
   );

   // result, write enable and flags
   always_comb begin
      res       = '0;
      we        = 1'b1;
      set_nz    = 1'b1;
      flags_new = flags_cur;
      unique case (fn)
         FN_AND: res = req.operand_n & req.operand_m;
         FN_EOR: res = req.operand_n ^ req.operand_m;
         FN_TST: begin
            res = req.operand_n & req.operand_m;
            we  = 1'b0;
         end
         FN_TEQ: begin
            res = req.operand_n ^ req.operand_m;
            we  = 1'b0;
         end
         FN_SUB, FN_RSB, FN_ADD, FN_ADC, FN_SBC, FN_RSC: begin
            res         = add_sum[DATA_W-1:0];
            flags_new.c = add_sum[DATA_W];
            flags_new.v = add_v;
         end
         FN_CMP, FN_CMN: begin
            res         = add_sum[DATA_W-1:0];
            flags_new.c = add_sum[DATA_W];
            flags_new.v = add_v;
            we          = 1'b0;
         end
         FN_ORR: res = req.operand_n | req.operand_m;
         FN_MOV: res = req.operand_m;
         FN_BIC: res = req.operand_n & ~req.operand_m;
         FN_MVN: res = ~req.operand_m;
         FN_MOV2: begin
            res         = req.operand_n;
            flags_new.c = 1'b0;
            flags_new.v = 1'b0;
         end
         FN_LSL_IMM, FN_LSR_IMM, FN_ASR_IMM,
         FN_LSL_REG, FN_LSR_REG, FN_ASR_REG, FN_ROR_REG: begin
            res         = sh_value;
            flags_new.c = sh_carry;
         end
         default: begin
            // unused codes: no write, flags kept
            we     = 1'b0;
            set_nz = 1'b0;
         end
      endcase
      if (set_nz) begin
         flags_new.n = res[DATA_W-1];
         flags_new.z = (res == '0);
      end
   end

   assign rsp.result_value = res;
   assign rsp.write_enable = we;
   assign rsp.dest_out     = req.dest_reg;
   assign rsp.flags        = flags_new;
   assign rsp.pc_written   = we & (req.dest_reg == PC_REG);

endmodule

FILE: rtl/thumb_alu_shifter_with_flags_core.sv
// ---------------------------------------------------------------------------
// thumb_alu_shifter_with_flags_core: thumb execute stage with nzcv flags
// Input register, one-pass alu/shifter, output register and flag register.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation (func, operand_n, operand_m, shift_amount,
//   dest_reg); a request is taken when valid and ready are both high.
//   rsp_ch returns exactly one result per request, in order: value, write
//   enable, destination, the new N Z C V flags and the pc-written mark.
//   A taken request is held in the input register, computed there by the
//   alu and moved into the output register once that register is free,
//   which raises rsp valid.
//   Throughput: one request per cycle while rsp ready stays high; the
//   stored flags are updated in the same edge that moves a request into
//   the output register, so each request sees the flags of the one before it.
//   Reset (synchronous, active high) empties both registers and clears the
//   stored flags to zero.
//   When the receiver holds rsp ready low, the output register holds its
//   result and the input register still takes one more request; req ready
//   drops only when both are full.
// ---------------------------------------------------------------------------
module thumb_alu_shifter_with_flags_core (
   input  logic       clock,
   input  logic       reset,
   tasf_req_if.sink   req_ch,
   tasf_rsp_if.source rsp_ch
);
   import tasf_pkg::*;

   req_type   stage_ff;
   req_type   stage_in;
   logic      stage_valid_ff;
   logic      stage_valid_in;
   rsp_type   out_ff;
   rsp_type   out_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   flags_type flags_ff;
   flags_type flags_in;
   logic      advance;
   logic      req_take;

   // handshake and pipeline advance
   assign advance  = stage_valid_ff & (~out_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~stage_valid_ff | advance;
   assign req_take = req_ch.valid & req_ch.ready;

   // input register next values
   always_comb begin
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff & ~advance;
      if (req_take) begin
         stage_in.func         = req_ch.func;
         stage_in.operand_n    = req_ch.operand_n;
         stage_in.operand_m    = req_ch.operand_m;
         stage_in.shift_amount = req_ch.shift_amount;
         stage_in.dest_reg     = req_ch.dest_reg;
         stage_valid_in        = 1'b1;
      end
   end

   // execute logic
   rsp_type alu_rsp;

   tasf_alu u_alu (
      .req       (stage_ff),
      .flags_cur (flags_ff),
      .rsp       (alu_rsp)
   );

   // output and flag register next values
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_ch.ready;
      flags_in     = flags_ff;
      if (advance) begin
         out_in       = alu_rsp;
         out_valid_in = 1'b1;
         flags_in     = alu_rsp.flags;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         flags_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         flags_ff       <= flags_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

   // response port
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_value = out_ff.result_value;
   assign rsp_ch.write_enable = out_ff.write_enable;
   assign rsp_ch.dest_out     = out_ff.dest_out;
   assign rsp_ch.flag_n       = out_ff.flags.n;
   assign rsp_ch.flag_z       = out_ff.flags.z;
   assign rsp_ch.flag_c       = out_ff.flags.c;
   assign rsp_ch.flag_v       = out_ff.flags.v;
   assign rsp_ch.pc_written   = out_ff.pc_written;

   // a taken request is held in the input register next cycle
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_take |=> stage_valid_ff)
      else $error("taken request not in input register");

   // a stalled request stays in the input register
   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("stalled request lost");

   // stored flags track the flags of the last result loaded
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> (flags_ff == out_ff.flags))
      else $error("stored flags differ from result flags");

   // pc mark only on a write to register 15
   a_pc_mark: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.pc_written ==
                        (out_ff.write_enable && out_ff.dest_out == PC_REG)))
      else $error("pc written mark inconsistent");

   // reset clears the flags
   a_reset_flags: assert property (@(posedge clock)
      reset |=> (flags_ff == '0))
      else $error("flags not cleared by reset");

endmodule
